// ===== hdl/decimal_number_scanner_defines.svh =====
// Assertion helpers for the decimal number scanner.
`ifndef DECIMAL_NUMBER_SCANNER_DEFINES_SVH
`define DECIMAL_NUMBER_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
`define DNS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DNS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DNS_ASSERT(name, prop, msg)
`define DNS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== hdl/dns_pkg.sv =====
package dns_pkg;

  typedef enum logic [2:0] {
    PhLead     = 3'd0,
    PhPostSign = 3'd1,
    PhInt      = 3'd2,
    PhFrac     = 3'd3,
    PhExpSign  = 3'd4,
    PhExpDig   = 3'd5,
    PhDone     = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        minus;
    logic [63:0] accum;
    logic [4:0]  digit_count;
    logic [9:0]  frac_count;
    logic [9:0]  drop_count;
    logic        exp_neg;
    logic [8:0]  exp_accum;
    logic        lost;
  } parse_t;

  typedef struct packed {
    logic        negative;
    logic [63:0] mantissa;
    logic [11:0] dec_exponent;
    logic        precision_lost;
  } result_t;

  localparam logic [4:0] MaxDigits = 5'd19;
  localparam logic [8:0] MaxExp    = 9'd308;
  localparam logic [9:0] CntMax    = 10'd1023;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChLowerE = 8'h65;

  localparam logic [7:0] MarkReset      = 8'h2E;
  localparam logic       RegDecimalMark = 1'b0;

  localparam parse_t ParseReset = '{
    phase: PhLead, minus: 1'b0, accum: 64'd0, digit_count: 5'd0, frac_count: 10'd0,
    drop_count: 10'd0, exp_neg: 1'b0, exp_accum: 9'd0, lost: 1'b0
  };

endpackage

// ===== hdl/dns_step.sv =====
module dns_step (
  input  dns_pkg::parse_t  state_i,
  input  logic [7:0]       char_code_i,
  input  logic [7:0]       decimal_mark_i,
  output dns_pkg::parse_t  state_o,
  output dns_pkg::result_t result_o
);
  import dns_pkg::*;

  function automatic parse_t take_digit(parse_t s, logic [3:0] d, logic frac);
    logic [63:0] acc;
    parse_t      r;
    r   = s;
    acc = {s.accum[60:0], 3'b000} + {s.accum[62:0], 1'b0} + {60'd0, d};
    if (s.digit_count < MaxDigits) begin
      if (frac && (s.frac_count >= CntMax)) begin
        r.lost = 1'b1;
      end else begin
        if (frac) r.frac_count = s.frac_count + 10'd1;
        r.accum = acc;
        if (acc != 64'd0) r.digit_count = s.digit_count + 5'd1;
      end
    end else begin
      r.lost = 1'b1;
      if (!frac && (s.drop_count < CntMax)) r.drop_count = s.drop_count + 10'd1;
    end
    return r;
  endfunction

  logic        is_blank;
  logic        is_digit;
  logic        is_exp_mark;
  logic [3:0]  digit;
  logic [12:0] exp_next;
  logic        done;
  parse_t      st;
  logic signed [12:0] exp_sum;

  assign is_blank    = (char_code_i == ChSpace) || (char_code_i == ChTab);
  assign is_digit    = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign is_exp_mark = (char_code_i == ChLowerE) || (char_code_i == ChUpperE);
  assign digit       = 4'(char_code_i - ChZero);
  assign exp_next    = {1'b0, state_i.exp_accum, 3'b000} + {3'b000, state_i.exp_accum, 1'b0}
                     + {9'd0, digit};

  // Phases fall through within one character, as a non-fitting char moves on.
  always_comb begin
    st   = state_i;
    done = 1'b0;
    if (st.phase == PhLead) begin
      if (is_blank) begin
        done = 1'b1;
      end else if (char_code_i == ChMinus) begin
        st.minus = 1'b1;
        st.phase = PhPostSign;
        done     = 1'b1;
      end else if (char_code_i == ChPlus) begin
        st.phase = PhPostSign;
        done     = 1'b1;
      end else begin
        st.phase = PhPostSign;
      end
    end
    if (!done && st.phase == PhPostSign) begin
      if (is_blank) done = 1'b1;
      else st.phase = PhInt;
    end
    if (!done && st.phase == PhInt) begin
      done = 1'b1;
      if (is_digit) st = take_digit(st, digit, 1'b0);
      else if (char_code_i == decimal_mark_i) st.phase = PhFrac;
      else if (is_exp_mark) st.phase = PhExpSign;
      else st.phase = PhDone;
    end
    if (!done && st.phase == PhFrac) begin
      done = 1'b1;
      if (is_digit) st = take_digit(st, digit, 1'b1);
      else if (is_exp_mark) st.phase = PhExpSign;
      else st.phase = PhDone;
    end
    if (!done && st.phase == PhExpSign) begin
      if (char_code_i == ChMinus) begin
        st.exp_neg = 1'b1;
        st.phase   = PhExpDig;
        done       = 1'b1;
      end else if (char_code_i == ChPlus) begin
        st.phase = PhExpDig;
        done     = 1'b1;
      end else begin
        st.phase = PhExpDig;
      end
    end
    if (!done && st.phase == PhExpDig) begin
      if (is_digit) begin
        st.exp_accum = (exp_next > {4'd0, MaxExp}) ? MaxExp : exp_next[8:0];
      end else begin
        st.phase = PhDone;
      end
    end
  end

  always_comb begin
    exp_sum = $signed({3'b000, st.drop_count}) - $signed({3'b000, st.frac_count});
    if (st.exp_neg) exp_sum = exp_sum - $signed({4'd0, st.exp_accum});
    else exp_sum = exp_sum + $signed({4'd0, st.exp_accum});
  end

  assign state_o                 = st;
  assign result_o.negative       = st.minus;
  assign result_o.mantissa       = st.accum;
  assign result_o.dec_exponent   = exp_sum[11:0];
  assign result_o.precision_lost = st.lost;

endmodule

// ===== hdl/decimal_number_scanner.sv =====
// Decimal number scanner: takes number text one character per transfer, is_last
// on the final character, and returns one result (sign, 64-bit decimal mantissa
// of at most 19 significant digits, signed decimal exponent, precision-lost flag)
// for each text. One character per cycle is sustained; the result is registered
// as the last character leaves the input register. The input stalls only while
// a last character waits for a result that has not been taken. The rate is set
// by the parse step, whose longest path is the multiply-by-ten add on the 64-bit
// mantissa accumulator. The decimal mark register (address 0, reset '.') should
// only be written while no text is in flight.
`include "decimal_number_scanner_defines.svh"

module decimal_number_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_code_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               negative_o,
  output logic [63:0]        mantissa_o,
  output logic signed [11:0] dec_exponent_o,
  output logic               precision_lost_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dns_pkg::*;

  logic       s1_valid_q;
  logic       s1_last_q;
  logic [7:0] s1_char_q;
  logic       proceed;
  logic       out_valid_q;
  logic [7:0] mark_q;
  parse_t     state_q;
  parse_t     state_next;
  result_t    result;
  result_t    result_q;

  dns_step u_step (
    .state_i        (state_q),
    .char_code_i    (s1_char_q),
    .decimal_mark_i (mark_q),
    .state_o        (state_next),
    .result_o       (result)
  );

  // A character without is_last never needs the output slot.
  assign proceed    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || proceed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_last_q  <= is_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_char_q <= char_code_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ParseReset;
      out_valid_q <= 1'b0;
    end else begin
      if (proceed) state_q <= s1_last_q ? ParseReset : state_next;
      if (proceed && s1_last_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && s1_last_q) result_q <= result;
  end

  // Config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= MarkReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegDecimalMark)) begin
      mark_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDecimalMark) ? {24'd0, mark_q} : 32'd0;

  assign out_valid_o      = out_valid_q;
  assign negative_o       = result_q.negative;
  assign mantissa_o       = result_q.mantissa;
  assign dec_exponent_o   = $signed(result_q.dec_exponent);
  assign precision_lost_o = result_q.precision_lost;

  `DNS_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(proceed && s1_last_q), "result without last character")
  `DNS_ASSERT_NEXT(a_clear_after_last, proceed && s1_last_q, state_q.phase == PhLead && state_q.accum == 64'd0 && out_valid_q, "parse state not cleared after result")
  `DNS_ASSERT(a_digit_bound, state_q.digit_count <= MaxDigits, "digit count beyond limit")
  `DNS_ASSERT(a_exp_bound, state_q.exp_accum <= MaxExp, "exponent beyond clamp")
  `DNS_ASSERT(a_stall_cause, !in_ready_o |-> (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i), "input stalled without full output")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dns_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int HoldAfterResults = 12;
  localparam int SettleCycles = 6;
  localparam int SegmentChars = 95;
  localparam logic [2:0] MarkAddr = {RegDecimalMark, 2'b00};

  typedef bit [7:0] text_t[$];

  // Expected-number tracker: mirrors the parse state and queues one number per text.
  class number_checker;
    phase_e      ph;
    bit          minus;
    bit [63:0]   accum;
    bit [4:0]    kept_digits;
    bit [9:0]    frac_digits;
    bit [9:0]    dropped_digits;
    bit          exp_minus;
    bit [8:0]    exp_value;
    bit          lost;
    bit [7:0]    mark;
    result_t     expected_numbers[$];
    int          mismatches;

    function new();
      mark = MarkReset;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      ph = PhLead;
      minus = 1'b0;
      accum = '0;
      kept_digits = '0;
      frac_digits = '0;
      dropped_digits = '0;
      exp_minus = 1'b0;
      exp_value = '0;
      lost = 1'b0;
    endfunction

    function void add_digit(bit [7:0] c, bit in_fraction);
      if (kept_digits < MaxDigits) begin
        if (in_fraction) begin
          if (frac_digits >= CntMax) begin
            lost = 1'b1;
            return;
          end
          frac_digits++;
        end
        accum = accum * 64'd10 + 64'(c - ChZero);
        if (accum != 0) kept_digits++;
      end else begin
        lost = 1'b1;
        if (!in_fraction && dropped_digits < CntMax) dropped_digits++;
      end
    endfunction

    function void take_char(bit [7:0] c, bit last);
      bit      done;
      bit      blank;
      bit      digit;
      bit      exp_mark;
      int      v;
      result_t r;
      done = 1'b0;
      blank = (c == ChSpace) || (c == ChTab);
      digit = (c >= ChZero) && (c <= ChNine);
      exp_mark = (c == ChLowerE) || (c == ChUpperE);
      if (ph == PhLead) begin
        if (blank) done = 1'b1;
        else if (c == ChMinus) begin
          minus = 1'b1;
          ph = PhPostSign;
          done = 1'b1;
        end else if (c == ChPlus) begin
          ph = PhPostSign;
          done = 1'b1;
        end else ph = PhPostSign;
      end
      if (!done && ph == PhPostSign) begin
        if (blank) done = 1'b1;
        else ph = PhInt;
      end
      if (!done && ph == PhInt) begin
        done = 1'b1;
        // digits win over a mark that equals a digit
        if (digit) add_digit(c, 1'b0);
        else if (c == mark) ph = PhFrac;
        else if (exp_mark) ph = PhExpSign;
        else ph = PhDone;
      end
      if (!done && ph == PhFrac) begin
        done = 1'b1;
        if (digit) add_digit(c, 1'b1);
        else if (exp_mark) ph = PhExpSign;
        else ph = PhDone;
      end
      if (!done && ph == PhExpSign) begin
        if (c == ChMinus) begin
          exp_minus = 1'b1;
          ph = PhExpDig;
          done = 1'b1;
        end else if (c == ChPlus) begin
          ph = PhExpDig;
          done = 1'b1;
        end else ph = PhExpDig;
      end
      if (!done && ph == PhExpDig) begin
        if (digit) begin
          v = int'(exp_value) * 10 + int'(c - ChZero);
          exp_value = (v > int'(MaxExp)) ? MaxExp : 9'(v);
        end else ph = PhDone;
      end
      if (!last) return;
      v = int'(dropped_digits) - int'(frac_digits)
          + (exp_minus ? -int'(exp_value) : int'(exp_value));
      r.negative = minus;
      r.mantissa = accum;
      r.dec_exponent = v[11:0];
      r.precision_lost = lost;
      expected_numbers.push_back(r);
      restart();
    endfunction

    task report_mismatch(string what);
      if (mismatches < 30) $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_number(logic neg, logic [63:0] man, logic [11:0] ex, logic lost_o);
      result_t want;
      if (expected_numbers.size() == 0) begin
        report_mismatch("number out with no text pending");
        return;
      end
      want = expected_numbers.pop_front();
      if (neg !== want.negative)
        report_mismatch($sformatf("negative %b, want %b", neg, want.negative));
      if (man !== want.mantissa)
        report_mismatch($sformatf("mantissa %0d, want %0d", man, want.mantissa));
      if (ex !== want.dec_exponent)
        report_mismatch($sformatf("dec_exponent %0d, want %0d",
                                  $signed(ex), $signed(want.dec_exponent)));
      if (lost_o !== want.precision_lost)
        report_mismatch($sformatf("precision_lost %b, want %b", lost_o,
                                  want.precision_lost));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         char_code_i = '0;
  logic               is_last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               negative_o;
  logic [63:0]        mantissa_o;
  logic signed [11:0] dec_exponent_o;
  logic               precision_lost_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  number_checker checker_h = new();
  int            burst_left = 0;
  bit            gaps_on = 1'b1;
  int            numbers_seen = 0;
  int            idle_cycles = 0;

  decimal_number_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .is_last_i       (is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .negative_o      (negative_o),
    .mantissa_o      (mantissa_o),
    .dec_exponent_o  (dec_exponent_o),
    .precision_lost_o(precision_lost_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_char(input bit [7:0] c, input bit last);
    int gap;
    in_valid_i <= 1'b1;
    char_code_i <= c;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    checker_h.take_char(c, last);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 5);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  // drain all pending numbers, then give the pipe time to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (checker_h.expected_numbers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mark(input bit [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MarkAddr;
    pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    checker_h.mark = v;
  endtask

  // mostly well-formed numbers with random content; some noise and broken ones
  function automatic text_t make_text(bit [7:0] mark);
    text_t t;
    int    kind;
    int    n;
    bit    nines;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
      return t;
    end
    nines = kind < 18;
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) t.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
    case ($urandom_range(0, 2))
      0: t.push_back(ChMinus);
      1: t.push_back(ChPlus);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) t.push_back(ChSpace);
    n = nines ? 19 : (kind < 22 ? $urandom_range(19, 24) : $urandom_range(0, 6));
    repeat (n) t.push_back(nines ? ChNine : ChZero + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 2) != 0) begin
      t.push_back(mark);
      n = (kind >= 22 && kind < 26) ? $urandom_range(15, 25) : $urandom_range(0, 6);
      repeat (n) t.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      t.push_back($urandom_range(0, 1) ? ChLowerE : ChUpperE);
      case ($urandom_range(0, 2))
        0: t.push_back(ChMinus);
        1: t.push_back(ChPlus);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) t.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
    if (kind >= 85 && t.size() > 0)
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) t.push_back(8'($urandom_range(0, 255)));
    if (t.size() == 0) t.push_back(8'($urandom_range(0, 255)));
    return t;
  endfunction

  // result side: its own stall pattern plus one long hold-off
  initial begin
    int  hold_left;
    int  rx_cycle;
    bit  held;
    bit  ready;
    hold_left = 0;
    rx_cycle = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        checker_h.check_number(negative_o, mantissa_o, dec_exponent_o, precision_lost_o);
        numbers_seen++;
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (!held && numbers_seen >= HoldAfterResults) begin
        held = 1'b1;
        hold_left = HoldCycles;
        ready = 1'b0;
      end else begin
        case ((rx_cycle / 128) % 4)
          0: ready = 1'b1;
          1: ready = $urandom_range(0, 1) == 1;
          2: ready = (rx_cycle % 4) != 0;
          default: ready = $urandom_range(0, 9) != 0;
        endcase
      end
      out_ready_i <= ready;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit [7:0] marks[7];
    text_t    t;
    int       sent;
    marks = '{8'd0, 8'd255, 8'h2C, ChZero + 8'd5, ChSpace, ChLowerE, MarkReset};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short directed texts under the reset mark
    send_string("\t-");
    send_string("- 4");
    send_string("+1.5e-3");
    send_string("E");
    send_string("x9");
    send_string("12e+");
    send_string("0.0E99");
    send_string(" ");
    settle();

    foreach (marks[s]) begin
      write_mark(marks[s]);
      gaps_on = (s % 3) != 1;
      if (s == 2) begin
        // fraction counter saturation, lowest exponent
        t = {};
        t.push_back(ChZero);
        t.push_back(marks[s]);
        repeat (1030) t.push_back(ChZero);
        t.push_back(ChLowerE);
        t.push_back(ChMinus);
        repeat (3) t.push_back(ChNine);
        send_text(t);
        // dropped integer digit saturation, highest exponent
        t = {};
        repeat (19) t.push_back(ChZero + 8'd1);
        repeat (1030) t.push_back(ChZero + 8'd7);
        t.push_back(ChUpperE);
        repeat (3) t.push_back(ChNine);
        send_text(t);
      end
      sent = 0;
      while (sent < SegmentChars) begin
        t = make_text(marks[s]);
        sent += t.size();
        send_text(t);
      end
      settle();
    end

    if (checker_h.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
